// ===== rtl/core/clnorm_pkg.sv =====
// Package for the command line normalizer: character codes, parse mode codes,
// status codes, and the state and result types shared by the core and its step logic.
// No dependencies.
package clnorm_pkg;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_MAIN  = 3'd1;
   localparam logic [2:0] MODE_Q1    = 3'd2;
   localparam logic [2:0] MODE_Q2    = 3'd3;
   localparam logic [2:0] MODE_SQ    = 3'd4;
   localparam logic [2:0] MODE_TQ    = 3'd5;
   localparam logic [2:0] MODE_TQEND = 3'd6;
   localparam logic [2:0] MODE_SKIP  = 3'd7;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef struct packed {
      logic [2:0] parse_mode;
      logic       first_byte_flag;
      logic       last_was_space;
      logic       last_was_backslash;
      logic       escape_pending;
   } parse_state_type;

   localparam parse_state_type LINE_START = '{
      parse_mode:         MODE_START,
      first_byte_flag:    1'b1,
      last_was_space:     1'b1,
      last_was_backslash: 1'b0,
      escape_pending:     1'b0
   };

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       end_mark;
      logic [1:0] status;
   } result_type;

endpackage

// ===== rtl/core/clnorm_step.sv =====
// Next-state and result logic for one input byte of the command line normalizer.
// Purely combinational; depends on clnorm_pkg.
module clnorm_step import clnorm_pkg::*; (
   input  parse_state_type cur_state,
   input  logic [7:0]      in_byte,
   output parse_state_type nxt_state,
   output result_type      result
);

   logic is_hash, is_nl, is_quote, is_bsl, is_space;

   assign is_hash  = (in_byte == CH_HASH);
   assign is_nl    = (in_byte == CH_NL);
   assign is_quote = (in_byte == CH_QUOTE);
   assign is_bsl   = (in_byte == CH_BSL);
   assign is_space = (in_byte == CH_SPACE);

   always_comb begin
      parse_state_type nxt;
      logic            emit;
      logic            fin;
      logic [1:0]      fin_status;
      logic            main_go;
      logic            str_go;
      logic            triple;
      logic            lsp_v;
      logic            lbs_v;
      logic            esc_v;

      nxt        = cur_state;
      emit       = 1'b0;
      fin        = 1'b0;
      fin_status = STATUS_OK;
      main_go    = 1'b0;
      str_go     = 1'b0;
      triple     = 1'b0;
      lsp_v      = cur_state.last_was_space;
      lbs_v      = cur_state.last_was_backslash;
      esc_v      = cur_state.escape_pending;

      case (cur_state.parse_mode)
         MODE_START: begin
            if (cur_state.first_byte_flag && (is_hash || is_nl)) begin
               fin        = 1'b1;
               fin_status = STATUS_EMPTY;
            end else begin
               nxt.first_byte_flag = 1'b0;
               if (!is_space) begin
                  nxt.parse_mode = MODE_MAIN;
                  lsp_v          = 1'b1;
                  main_go        = 1'b1;
               end
            end
         end
         MODE_MAIN: begin
            main_go = 1'b1;
         end
         MODE_Q1: begin
            if (is_quote) begin
               nxt.parse_mode = MODE_Q2;
            end else begin
               nxt.parse_mode = MODE_SQ;
               lbs_v          = 1'b0;
               esc_v          = 1'b0;
               str_go         = 1'b1;
            end
         end
         MODE_Q2: begin
            if (is_quote) begin
               nxt.parse_mode         = MODE_TQ;
               nxt.last_was_backslash = 1'b0;
               nxt.escape_pending     = 1'b0;
            end else begin
               fin        = 1'b1;
               fin_status = STATUS_ERROR;
            end
         end
         MODE_SQ: begin
            str_go = 1'b1;
         end
         MODE_TQ: begin
            str_go = 1'b1;
            triple = 1'b1;
         end
         MODE_TQEND: begin
            fin        = 1'b1;
            fin_status = is_quote ? STATUS_OK : STATUS_ERROR;
         end
         default: begin
            if (is_nl) begin
               nxt = LINE_START;
            end
         end
      endcase

      if (main_go) begin
         nxt.last_was_space = lsp_v;
         if (is_space) begin
            if (!lsp_v) begin
               nxt.last_was_space = 1'b1;
               emit               = 1'b1;
            end
         end else if (is_quote) begin
            nxt.parse_mode = MODE_Q1;
            emit           = 1'b1;
         end else if (is_hash || is_nl) begin
            fin        = 1'b1;
            fin_status = STATUS_OK;
         end else begin
            nxt.last_was_space = 1'b0;
            emit               = 1'b1;
         end
      end

      if (str_go) begin
         nxt.last_was_backslash = lbs_v;
         nxt.escape_pending     = esc_v;
         if (!esc_v && is_bsl) begin
            nxt.escape_pending     = 1'b1;
            nxt.last_was_backslash = 1'b1;
         end else begin
            nxt.escape_pending = 1'b0;
            if (is_quote) begin
               if (lbs_v) begin
                  nxt.last_was_backslash = 1'b0;
                  emit                   = 1'b1;
               end else if (triple) begin
                  nxt.parse_mode = MODE_TQEND;
               end else begin
                  fin        = 1'b1;
                  fin_status = STATUS_OK;
               end
            end else if (!triple && is_nl) begin
               fin        = 1'b1;
               fin_status = STATUS_ERROR;
            end else begin
               nxt.last_was_backslash = is_bsl;
               emit                   = 1'b1;
            end
         end
      end

      if (fin) begin
         nxt = LINE_START;
         if (!is_nl) begin
            nxt.parse_mode = MODE_SKIP;
         end
      end

      nxt_state       = nxt;
      result.valid    = emit || fin;
      result.out_byte = fin ? 8'h00 : in_byte;
      result.end_mark = fin;
      result.status   = fin ? fin_status : STATUS_OK;
   end

endmodule

// ===== rtl/core/command_line_normalizer_core.sv =====
// Top level of the command line normalizer: parse state registers, the result
// register and the stream handshakes. Depends on clnorm_pkg and clnorm_step.
//
//   Channel   Direction  Payload
//   req_      in         tdata[7:0] = in_byte
//   rsp_      out        tdata[7:0] = out_byte, tlast = end_mark, tuser[1:0] = status
//
// The result of each accepted byte is written to the result register as the byte is accepted, and a new
// byte is accepted every cycle while the result register is empty or being drained.
// The parse state and the result register are updated together from one level of step logic.
// Reset returns the parser to the start of a line and empties the result register.
// A stalled result holds req_tready low until the result transaction completes.
module command_line_normalizer_core import clnorm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser    // [1:0] status
);

   parse_state_type state_ff, state_in;
   parse_state_type step_state;
   result_type      step_result;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic            req_accept;

   clnorm_step u_step (
      .cur_state (state_ff),
      .in_byte   (req_tdata),
      .nxt_state (step_state),
      .result    (step_result)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (req_accept) begin
         state_in     = step_state;
         rsp_valid_in = step_result.valid;
         if (step_result.valid) begin
            rsp_byte_in   = step_result.out_byte;
            rsp_last_in   = step_result.end_mark;
            rsp_status_in = step_result.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LINE_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == 8'h00))
      else $error("End marker carries a nonzero byte.");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == STATUS_OK))
      else $error("Data byte carries a nonzero status.");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_EMPTY ||
                      rsp_tuser == STATUS_ERROR))
      else $error("Illegal status code.");

   a_end_restarts_line: assert property (@(posedge clock) disable iff (reset)
      (req_accept && step_result.end_mark) |=>
         (state_ff.first_byte_flag &&
          (state_ff.parse_mode == MODE_START || state_ff.parse_mode == MODE_SKIP)))
      else $error("Parser did not return to a new line after an end marker.");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("Input accepted while a result is stalled.");

endmodule
